// ===== hw/rtl/brt_pkg.sv =====
package brt_pkg;

  localparam int ZW         = 24;   // z statistic width
  localparam int SCW        = 20;   // sample count width
  localparam int ZCW        = 16;   // critical value width
  localparam int QW         = 50;   // saturated quotient width
  localparam int RW         = QW / 2;
  localparam int SRW        = RW + 3;
  localparam int FRAC_SHIFT = 26;   // (2*4096)^2 scaling of z^2
  localparam int THRW       = 2 * ZCW + 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ZW-1:0]  Z_NEG_LIM   = 24'h800000;
  localparam logic [ZW-1:0]  Z_POS_LIM   = 24'h7FFFFF;
  localparam logic [SCW-1:0] SC_MAX      = 20'hFFFFF;
  localparam logic [ZCW-1:0] ZCRIT_RESET = 16'd8028;

  // register index, taken from paddr[2]
  localparam logic REG_ZCRIT = 1'b0;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 reject;
  } brt_res_t;

endpackage

// ===== hw/rtl/binary_runs_test_unit.sv =====
// Runs test over a bit stream. Non-final beats are taken one per cycle while the
// core is not busy. A final beat starts the z computation on one shared adder:
// shift-add products (one step per multiplier bit), a 5*COUNT_BITS+26 step long
// divide and a 25 step square root; input ready stays low until the result is in
// the output register. Synchronous active-low reset clears the counters, the
// output valid and sets z_critical to 1.96.
module binary_runs_test_unit import brt_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // bit stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_sample_bit,
  input  logic                 in_last_sample,
  // result
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [ZW-1:0] out_z_statistic,
  output logic [SCW-1:0]       out_sample_count,
  output logic                 out_reject_random,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int C  = COUNT_BITS;
  localparam int XW = (C > SCW) ? C : SCW;

  logic [C-1:0]   ones_r, zeros_r, runs_r;
  logic [C-1:0]   ones_nxt, zeros_nxt, runs_nxt, n_cur, n_nxt;
  logic           prev_r, prev_nxt;
  logic           busy_r;
  logic [ZCW-1:0] zcrit_r;
  logic [SCW-1:0] cnt_hold_r, cnt_nxt;
  logic [XW-1:0]  n_ext;
  logic           in_beat, last_beat, core_done, core_ack;
  brt_res_t       core_res;

  logic                 out_valid_r;
  logic signed [ZW-1:0] out_z_r;
  logic [SCW-1:0]       out_cnt_r;
  logic                 out_rej_r;

  assign in_ready  = !busy_r;
  assign in_beat   = in_valid && in_ready;
  assign last_beat = in_beat && in_last_sample;

  // counter update; bits past a full counter are dropped
  assign n_cur = ones_r + zeros_r;
  always_comb begin
    ones_nxt  = ones_r;
    zeros_nxt = zeros_r;
    runs_nxt  = runs_r;
    prev_nxt  = prev_r;
    if (n_cur != {C{1'b1}}) begin
      if (n_cur == '0) begin
        runs_nxt = C'(1);
      end else if (in_sample_bit != prev_r) begin
        runs_nxt = runs_r + 1'b1;
      end
      if (in_sample_bit) begin
        ones_nxt = ones_r + 1'b1;
      end else begin
        zeros_nxt = zeros_r + 1'b1;
      end
      prev_nxt = in_sample_bit;
    end
  end

  // reported count: 0 below two samples, saturated above the field
  assign n_nxt = ones_nxt + zeros_nxt;
  assign n_ext = XW'(n_nxt);
  always_comb begin
    if (n_ext < XW'(2)) begin
      cnt_nxt = '0;
    end else if (n_ext > XW'(SC_MAX)) begin
      cnt_nxt = SC_MAX;
    end else begin
      cnt_nxt = n_ext[SCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r  <= '0;
      zeros_r <= '0;
      runs_r  <= '0;
      prev_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (last_beat) begin
        // counters clear as the sequence is handed to the core
        ones_r     <= '0;
        zeros_r    <= '0;
        runs_r     <= '0;
        prev_r     <= 1'b0;
        busy_r     <= 1'b1;
        cnt_hold_r <= cnt_nxt;
      end else if (in_beat) begin
        ones_r  <= ones_nxt;
        zeros_r <= zeros_nxt;
        runs_r  <= runs_nxt;
        prev_r  <= prev_nxt;
      end
      if (core_done && core_ack) begin
        busy_r <= 1'b0;
      end
    end
  end

  brt_core #(.C(C)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (last_beat),
    .n1    (ones_nxt),
    .n0    (zeros_nxt),
    .runs  (runs_nxt),
    .zcrit (zcrit_r),
    .ack   (core_ack),
    .done  (core_done),
    .res   (core_res)
  );

  // output register: core result moves in when the slot is free
  assign core_ack = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_done && core_ack) begin
      out_valid_r <= 1'b1;
      out_z_r     <= core_res.z;
      out_rej_r   <= core_res.reject;
      out_cnt_r   <= cnt_hold_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_z_statistic   = out_z_r;
  assign out_sample_count  = out_cnt_r;
  assign out_reject_random = out_rej_r;

  // register port, zero wait states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zcrit_r <= ZCRIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_ZCRIT) begin
      zcrit_r <= pwdata[ZCW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZCRIT) ? PDATA_W'(zcrit_r) : '0;

  // runs never exceed samples, and are zero only on an empty sequence
  a_runs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (runs_r <= n_cur) && ((runs_r == '0) == (n_cur == '0)))
    else $error("runs counter out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_beat |=> (ones_r == '0) && (zeros_r == '0) && busy_r)
    else $error("counters not cleared after final beat");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cnt_r == '0) |-> (out_z_r == '0) && !out_rej_r)
    else $error("short sequence gave nonzero result");

  a_busy_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(in_valid && in_last_sample))
    else $error("core started without a final beat");

endmodule

// ===== hw/rtl/brt_addsub.sv =====
module brt_addsub import brt_pkg::*; #(
  parameter int W = 100
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  // sub: a - b, cout high means no borrow
  assign full = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

// ===== hw/rtl/brt_core.sv =====
module brt_core import brt_pkg::*; #(
  parameter int C = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [C-1:0]   n1,
  input  logic [C-1:0]   n0,
  input  logic [C-1:0]   runs,
  input  logic [ZCW-1:0] zcrit,
  input  logic           ack,
  output logic           done,
  output brt_res_t       res
);

  localparam int PW   = 2 * C;
  localparam int BW   = 4 * C;
  localparam int AW   = 5 * C;
  localparam int NUMW = AW + FRAC_SHIFT;
  localparam int CNTW = $clog2(NUMW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DIFF1 = 4'd2;
  localparam logic [3:0] S_DIFF2 = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SQI   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [2:0] PH_P    = 3'd0;  // n1*n0
  localparam logic [2:0] PH_B    = 3'd1;  // p2*(p2-n)
  localparam logic [2:0] PH_DPOS = 3'd2;  // n*(R-1)
  localparam logic [2:0] PH_DSQ  = 3'd3;  // dmag^2
  localparam logic [2:0] PH_N    = 3'd4;  // dmag^2*(n-1)

  logic [3:0]      state_r;
  logic [2:0]      phase_r;
  logic [C-1:0]    n_r, runs_r;
  logic [PW-1:0]   p2_r, my_r;
  logic [BW-1:0]   b_r, rem_r;
  logic [AW-1:0]   mx_r, acc_r;
  logic [NUMW-1:0] num_r;
  logic [QW-1:0]   q_r, sq_src_r;
  logic            ovf_r, neg_r;
  logic [RW-1:0]   root_r;
  logic [SRW-1:0]  srem_r;
  logic [CNTW-1:0] cnt_r;
  logic [THRW-1:0] thr_r;
  brt_res_t        res_r;

  logic [AW-1:0]   op_a, op_b, op_sum;
  logic            op_sub, op_cout;
  logic [BW:0]     div_sh;
  logic [SRW-1:0]  sq_cur;
  logic [PW-1:0]   dmag;
  logic [RW:0]     m_full;
  logic [ZW-1:0]   lo;
  brt_res_t        fin;

  assign div_sh = {rem_r, num_r[NUMW-1]};
  assign sq_cur = {srem_r[SRW-3:0], sq_src_r[QW-1 -: 2]};
  assign dmag   = op_sum[PW-1:0];

  // operand select for the shared adder
  always_comb begin
    op_a   = acc_r;
    op_b   = mx_r;
    op_sub = 1'b0;
    unique case (state_r)
      S_MUL: begin
        if (my_r == '0) begin
          op_sub = 1'b1;
          op_b   = AW'(1);
          if (phase_r == PH_P) begin
            op_a = AW'({acc_r[PW-2:0], 1'b0});
            op_b = AW'(n_r);
          end else if (phase_r == PH_B) begin
            op_a = AW'(runs_r);
          end else begin
            op_a = AW'(n_r);
          end
        end
      end
      S_DIFF1: begin
        op_b   = AW'(p2_r);
        op_sub = 1'b1;
      end
      S_DIFF2: begin
        op_a   = AW'(p2_r);
        op_b   = acc_r;
        op_sub = 1'b1;
      end
      S_DIV: begin
        op_a   = AW'(div_sh);
        op_b   = AW'(b_r);
        op_sub = 1'b1;
      end
      S_SQRT: begin
        op_a   = AW'(sq_cur);
        op_b   = AW'({root_r, 2'b01});
        op_sub = 1'b1;
      end
      default: ;
    endcase
  end

  brt_addsub #(.W(AW)) u_addsub (
    .a    (op_a),
    .b    (op_b),
    .sub  (op_sub),
    .sum  (op_sum),
    .cout (op_cout)
  );

  // final scaling: lo = ceil-half of root, clamped
  always_comb begin
    m_full = ({1'b0, root_r} + (RW+1)'(1)) >> 1;
    if (ovf_r || m_full >= (RW+1)'(Z_NEG_LIM)) begin
      lo = Z_NEG_LIM;
    end else begin
      lo = m_full[ZW-1:0];
    end
    if (neg_r) begin
      fin.z = ZW'(-lo);
    end else if (lo == Z_NEG_LIM) begin
      fin.z = Z_POS_LIM;
    end else begin
      fin.z = lo;
    end
    fin.reject = ovf_r || (q_r > QW'(thr_r)) || ((q_r == QW'(thr_r)) && (rem_r != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r    <= n1 + n0;
            runs_r <= runs;
            thr_r  <= {(2*ZCW)'(zcrit) * (2*ZCW)'(zcrit), 2'b00};
            res_r  <= '0;
            mx_r   <= AW'(n1);
            my_r   <= PW'(n0);
            acc_r  <= '0;
            phase_r <= PH_P;
            if (n1 == '0 || n0 == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (my_r != '0) begin
            if (my_r[0]) begin
              acc_r <= op_sum;
            end
            mx_r <= mx_r << 1;
            my_r <= my_r >> 1;
          end else begin
            acc_r <= '0;
            unique case (phase_r)
              PH_P: begin
                p2_r    <= {acc_r[PW-2:0], 1'b0};
                mx_r    <= AW'({acc_r[PW-2:0], 1'b0});
                my_r    <= op_sum[PW-1:0];
                phase_r <= PH_B;
              end
              PH_B: begin
                b_r     <= acc_r[BW-1:0];
                mx_r    <= AW'(n_r);
                my_r    <= PW'(op_sum[C-1:0]);
                phase_r <= PH_DPOS;
              end
              PH_DPOS: begin
                acc_r   <= acc_r;
                state_r <= S_DIFF1;
              end
              PH_DSQ: begin
                mx_r    <= acc_r;
                my_r    <= PW'(op_sum[C-1:0]);
                phase_r <= PH_N;
              end
              default: begin
                num_r   <= {acc_r, {FRAC_SHIFT{1'b0}}};
                rem_r   <= '0;
                q_r     <= '0;
                ovf_r   <= 1'b0;
                cnt_r   <= CNTW'(NUMW);
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_DIFF1, S_DIFF2: begin
          if (state_r == S_DIFF1 && !op_cout) begin
            neg_r   <= 1'b1;
            state_r <= S_DIFF2;
          end else begin
            if (state_r == S_DIFF1) begin
              neg_r <= 1'b0;
            end
            if (b_r == '0 || dmag == '0) begin
              state_r <= S_DONE;
            end else begin
              mx_r    <= AW'(dmag);
              my_r    <= dmag;
              acc_r   <= '0;
              phase_r <= PH_DSQ;
              state_r <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (op_cout) begin
            rem_r <= op_sum[BW-1:0];
          end else begin
            rem_r <= div_sh[BW-1:0];
          end
          q_r   <= {q_r[QW-2:0], op_cout};
          ovf_r <= ovf_r | q_r[QW-1];
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            state_r <= S_SQI;
          end
        end
        S_SQI: begin
          sq_src_r <= q_r;
          root_r   <= '0;
          srem_r   <= '0;
          cnt_r    <= CNTW'(RW);
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (op_cout) begin
            srem_r <= op_sum[SRW-1:0];
          end else begin
            srem_r <= sq_cur;
          end
          root_r   <= {root_r[RW-2:0], op_cout};
          sq_src_r <= sq_src_r << 2;
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r   <= fin;
          state_r <= S_DONE;
        end
        default: begin
          if (ack) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign done = (state_r == S_DONE);
  assign res  = res_r;

endmodule

// ===== test/testbench.sv =====
module testbench;
  import brt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [255:0] wide_t;

  // one result beat as the block should produce it
  typedef struct {
    logic signed [ZW-1:0] z;
    logic [SCW-1:0]       count;
    logic                 reject;
  } runs_result_t;

  // directed stimulus row; typed result used only when known_res is set
  typedef struct {
    logic                 sample;
    logic                 last;
    logic                 known_res;
    logic signed [ZW-1:0] z;
    logic [SCW-1:0]       count;
    logic                 reject;
  } dir_row_t;

  localparam int COUNT_BITS    = 20;
  localparam longint COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 2000;
  localparam int STALL_LIMIT   = 50000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_sample_bit;
  logic                 in_last_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [ZW-1:0] out_z_statistic;
  logic [SCW-1:0]       out_sample_count;
  logic                 out_reject_random;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  binary_runs_test_unit #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_bit(in_sample_bit), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_z_statistic(out_z_statistic), .out_sample_count(out_sample_count),
    .out_reject_random(out_reject_random),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state: counters and the shadow of z_critical
  longint unsigned ones_cnt, zeros_cnt, runs_cnt;
  logic            prev_sample;
  logic [ZCW-1:0]  zcrit_shadow;

  runs_result_t runs_expect_q[$];
  logic         use_typed;        // next beat's result comes from the table
  runs_result_t typed_res;

  int errors      = 0;
  int beats_in    = 0;
  int results_out = 0;
  int rejects_out = 0;
  bit hold_req    = 0;

  // sender burst bookkeeping
  int burst_left  = 0;

  function automatic void clear_runs();
    ones_cnt    = 0;
    zeros_cnt   = 0;
    runs_cnt    = 0;
    prev_sample = 1'b0;
  endfunction

  // Count one bit; on a last mark compute the runs z score exactly.
  // z^2 scaled by (2*4096)^2 is compared with (2k-1)^2 to round to nearest.
  function automatic bit runs_predict(input logic sample, input logic last,
                                      output runs_result_t res);
    longint unsigned n, p2, dpos, dmag, lo, hi, mid, k;
    bit              negative;
    wide_t           a4, b, t, thr;
    n = ones_cnt + zeros_cnt;
    if (n < COUNT_FULL) begin
      if (n == 0) runs_cnt = 1;
      else if (sample != prev_sample) runs_cnt++;
      if (sample) ones_cnt++;
      else zeros_cnt++;
      prev_sample = sample;
    end
    res.z      = '0;
    res.count  = '0;
    res.reject = 1'b0;
    if (!last) return 0;
    n = ones_cnt + zeros_cnt;
    res.count = (n < 2) ? '0 : SCW'(n);
    if (n >= 2 && ones_cnt != 0 && zeros_cnt != 0) begin
      p2       = 2 * ones_cnt * zeros_cnt;
      b        = wide_t'(p2) * wide_t'(p2 - n);
      dpos     = n * (runs_cnt - 1);
      negative = dpos < p2;
      dmag     = negative ? p2 - dpos : dpos - p2;
      a4       = (wide_t'(dmag) * wide_t'(dmag) * wide_t'(n - 1)) << FRAC_SHIFT;
      if (b != 0 && dmag != 0) begin
        lo  = 0;
        hi  = 64'd8388608;
        thr = b * wide_t'(4 * longint'(zcrit_shadow) * longint'(zcrit_shadow));
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          k   = 2 * mid - 1;
          t   = b * wide_t'(k * k);
          if (a4 >= t) lo = mid;
          else hi = mid - 1;
        end
        if (negative) res.z = ZW'(-lo);
        else res.z = (lo > 64'd8388607) ? Z_POS_LIM : ZW'(lo);
        res.reject = a4 > thr;
      end
    end
    clear_runs();
    return 1;
  endfunction

  // input monitor: every accepted beat goes through the predictor
  always @(posedge clk) begin
    runs_result_t r;
    if (rst_n && in_valid && in_ready) begin
      beats_in++;
      if (runs_predict(in_sample_bit, in_last_sample, r)) begin
        if (use_typed) r = typed_res;
        runs_expect_q.push_back(r);
      end
    end
  end

  // result checker: oldest expectation against each accepted result beat
  always @(posedge clk) begin
    runs_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_out++;
      if (out_reject_random) rejects_out++;
      if (runs_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat z=%0d count=%0d reject=%0b", $realtime,
                 out_z_statistic, out_sample_count, out_reject_random);
      end else begin
        e = runs_expect_q.pop_front();
        if (out_z_statistic !== e.z) begin
          errors++;
          $display("%0t: z_statistic expected %0d actual %0d", $realtime, e.z,
                   out_z_statistic);
        end
        if (out_sample_count !== e.count) begin
          errors++;
          $display("%0t: sample_count expected %0d actual %0d", $realtime, e.count,
                   out_sample_count);
        end
        if (out_reject_random !== e.reject) begin
          errors++;
          $display("%0t: reject_random expected %0b actual %0b", $realtime, e.reject,
                   out_reject_random);
        end
      end
    end
  end

  // receiver: random stall patterns in turn; a hold request gives
  // one long stretch of ready low so the block backs up into its input
  always begin
    int mode;
    mode = 0;
    @(negedge clk);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 0;
    end else begin
      mode = $urandom_range(3, 0);
      repeat (64) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(1, 0) == 1);
          2: out_ready <= ($urandom_range(9, 0) == 0);
          default: out_ready <= ($urandom_range(3, 0) != 0);
        endcase
        @(negedge clk);
        if (hold_req) break;
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $realtime, quiet);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Offer one beat at the falling edge and hold it until accepted. With
  // gapped set, the sender works in bursts with random idle cycles between.
  task automatic send_beat(input logic sample, input logic last, input bit gapped);
    if (gapped && burst_left == 0) begin
      repeat ($urandom_range(6, 0)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(20, 1);
    end
    if (gapped) burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_sample_bit  <= sample;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    drop_valid();
    while (runs_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write (setup then access) with a read back
  task automatic write_zcrit(input logic [ZCW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    zcrit_shadow = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[ZCW-1:0] !== value) begin
      errors++;
      $display("%0t: z_critical read expected %0d actual %0d", $realtime, value,
               prdata[ZCW-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random sequence: mostly short, some long, a few single bits.
  // The bias of the bits is drawn per sequence so z lands on both sides.
  task automatic send_sequence(output int sent);
    int len, bias, style;
    logic b;
    style = $urandom_range(19, 0);
    if (style == 0) len = 1;
    else if (style < 4) len = $urandom_range(300, 41);
    else len = $urandom_range(40, 2);
    bias = $urandom_range(100, 0);
    b = $urandom_range(1, 0);
    for (int i = 0; i < len; i++) begin
      case (style % 4)
        0: b = ($urandom_range(99, 0) < bias);      // biased coin
        1: b = ~b;                                   // alternating, many runs
        2: if ($urandom_range(9, 0) == 0) b = ~b;    // long runs
        default: b = $urandom_range(1, 0);
      endcase
      send_beat(b, (i == len - 1), 1'b1);
    end
    sent = len;
  endtask

  dir_row_t dir_rows[24];
  logic [ZCW-1:0] zcrit_plan[5];

  initial begin
    int sent, total;
    dir_rows = '{
      // lone last mark: fewer than two bits
      '{1'b0, 1'b1, 1'b1, '0, '0, 1'b0},
      '{1'b1, 1'b1, 1'b1, '0, '0, 1'b0},
      // all ones, all zeros
      '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b1, 1'b1, 1'b1, '0, 20'd2, 1'b0},
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b1, 1'b1, '0, 20'd2, 1'b0},
      // one of each: zero variance floored
      '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b1, 1'b1, '0, 20'd2, 1'b0},
      // alternating: too many runs
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b1, 1'b0, '0, '0, 1'b0},
      // two blocks: too few runs
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
      '{1'b1, 1'b0, 1'b0, '0, '0, 1'b0}, '{1'b1, 1'b1, 1'b0, '0, '0, 1'b0}
    };
    zcrit_plan = '{16'd0, 16'hFFFF, 16'd4096, 16'd8028, 16'd0};
    zcrit_plan[4] = ZCW'($urandom_range(16'hFFFF, 0));

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample_bit  = 1'b0;
    in_last_sample = 1'b0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    use_typed      = 1'b0;
    typed_res      = '{z: '0, count: '0, reject: 1'b0};
    clear_runs();
    zcrit_shadow = ZCRIT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset value of z_critical, no gaps; the typed
    // result flag updates after the previous beat has been sampled
    foreach (dir_rows[i]) begin
      use_typed <= dir_rows[i].known_res;
      typed_res <= '{z: dir_rows[i].z, count: dir_rows[i].count,
                     reject: dir_rows[i].reject};
      send_beat(dir_rows[i].sample, dir_rows[i].last, 1'b0);
    end
    drop_valid();
    @(negedge clk);
    use_typed = 1'b0;
    drain();

    // random part, one phase per z_critical setting
    foreach (zcrit_plan[p]) begin
      write_zcrit(zcrit_plan[p]);
      total = 0;
      if (p == 1) hold_req = 1;   // long receiver hold while bits keep coming
      while (total < 370) begin
        send_sequence(sent);
        total += sent;
      end
      drain();
    end

    $display("covered %0d input beats and %0d results (%0d rejects)", beats_in,
             results_out, rejects_out);
    $display("z_critical settings 0, max, 1.0, 1.96, random; one long output hold");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
